// ===== design/affine_transform_inverse_core_assert.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the affine inverse core
// Immediate-consequence and next-cycle property wrappers; empty when SYNTH.
// ----------------------------------------------------------------------------
`ifndef AFFINE_TRANSFORM_INVERSE_CORE_ASSERT_SVH
`define AFFINE_TRANSFORM_INVERSE_CORE_ASSERT_SVH
`ifndef SYNTH
// Consequent must hold in the same cycle as the antecedent.
`define ATI_ASSERT_IMP(name, ck, rs, ante, cons) \
  name: assert property (@(posedge ck) disable iff (rs) (ante) |-> (cons)) \
    else $error("ati: assertion failed");
// Consequent must hold in the cycle after the antecedent.
`define ATI_ASSERT_NEXT(name, ck, rs, ante, cons) \
  name: assert property (@(posedge ck) disable iff (rs) (ante) |=> (cons)) \
    else $error("ati: assertion failed");
`else
`define ATI_ASSERT_IMP(name, ck, rs, ante, cons)
`define ATI_ASSERT_NEXT(name, ck, rs, ante, cons)
`endif
`endif

// ===== design/ati_pkg.sv =====
// ----------------------------------------------------------------------------
// ati_pkg
// Shared widths, register codes and item types of the affine inverse core.
// ----------------------------------------------------------------------------
package ati_pkg;

  localparam int DATA_WIDTH    = 32;
  localparam int FRAC_BITS_DEF = 16;
  localparam int COF_WIDTH     = 2 * DATA_WIDTH + 1;
  localparam int DET_WIDTH     = 3 * DATA_WIDTH + 3;

  localparam int APB_WIDTH  = 32;
  localparam int ADDR_WIDTH = 3;
  localparam int THR_WIDTH  = 31;
  localparam logic [0:0] REG_MIN_DET_THR = 1'b0;

  localparam logic [1:0] ROW0 = 2'd0;
  localparam logic [1:0] ROW1 = 2'd1;
  localparam logic [1:0] ROW2 = 2'd2;

  typedef struct packed {
    logic signed [DATA_WIDTH-1:0] m00;
    logic signed [DATA_WIDTH-1:0] m01;
    logic signed [DATA_WIDTH-1:0] m02;
    logic signed [DATA_WIDTH-1:0] m10;
    logic signed [DATA_WIDTH-1:0] m11;
    logic signed [DATA_WIDTH-1:0] m12;
    logic signed [DATA_WIDTH-1:0] m20;
    logic signed [DATA_WIDTH-1:0] m21;
    logic signed [DATA_WIDTH-1:0] m22;
    logic signed [DATA_WIDTH-1:0] tx;
    logic signed [DATA_WIDTH-1:0] ty;
    logic signed [DATA_WIDTH-1:0] tz;
  } in_item_t;

  typedef struct packed {
    logic [1:0]                   row_index;
    logic signed [DATA_WIDTH-1:0] col0;
    logic signed [DATA_WIDTH-1:0] col1;
    logic signed [DATA_WIDTH-1:0] col2;
    logic signed [DATA_WIDTH-1:0] trans;
    logic                         singular;
    logic signed [DATA_WIDTH-1:0] w_out;
    logic                         last;
  } out_item_t;

  // Operands of one row: cofactor j = fac[4j]*fac[4j+1] - fac[4j+2]*fac[4j+3].
  typedef struct packed {
    logic                        valid;
    logic [1:0]                  row;
    logic [11:0][DATA_WIDTH-1:0] fac;
    logic [2:0][DATA_WIDTH-1:0]  mcol;
    logic [2:0][DATA_WIDTH-1:0]  tv;
  } row_ops_t;

  // Magnitudes and signs of one row, ready for the dividers.
  typedef struct packed {
    logic                       valid;
    logic [1:0]                 row;
    logic                       singular;
    logic                       det_neg;
    logic                       num_neg;
    logic [2:0]                 cof_neg;
    logic [DET_WIDTH-1:0]       adet;
    logic [DET_WIDTH-1:0]       anum;
    logic [2:0][COF_WIDTH-1:0]  acof;
  } front_t;

endpackage

// ===== design/ati_cfg.sv =====
// ----------------------------------------------------------------------------
// ati_cfg
// APB register file holding the singular-determinant threshold.
// ----------------------------------------------------------------------------
module ati_cfg import ati_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [ADDR_WIDTH-1:0] paddr,
  input  logic [APB_WIDTH-1:0]  pwdata,
  output logic [APB_WIDTH-1:0]  prdata,
  output logic                  pready,
  output logic [THR_WIDTH-1:0]  thr
);

  logic [ADDR_WIDTH-3:0] reg_idx;

  assign reg_idx = paddr[ADDR_WIDTH-1:2];
  assign pready  = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      thr <= '0;
    end else if (psel && penable && pwrite && (reg_idx == REG_MIN_DET_THR)) begin
      thr <= pwdata[THR_WIDTH-1:0];
    end
  end

  assign prdata = (reg_idx == REG_MIN_DET_THR) ?
                  {{(APB_WIDTH-THR_WIDTH){1'b0}}, thr} : '0;

endmodule

// ===== design/ati_row_seq.sv =====
// ----------------------------------------------------------------------------
// ati_row_seq
// Holds an accepted item and issues its three rows on consecutive cycles.
// ----------------------------------------------------------------------------
module ati_row_seq import ati_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     start,
  input  in_item_t xform,
  output logic     busy,
  output row_ops_t ops
);

  in_item_t   hold;
  logic       active;
  logic [1:0] cnt;
  row_ops_t   ops_next;
  logic       accept;

  assign busy   = active && (cnt != ROW2);
  assign accept = start && !busy;

  // Each row pulls the 2x2 minors of its adjugate row and column i of M,
  // whose dot product with that row gives the determinant.
  always_comb begin
    ops_next       = '0;
    ops_next.valid = active;
    ops_next.row   = cnt;
    ops_next.tv    = {hold.tz, hold.ty, hold.tx};
    unique case (cnt)
      ROW0: begin
        ops_next.fac  = {hold.m02, hold.m11, hold.m12, hold.m01,
                         hold.m22, hold.m01, hold.m02, hold.m21,
                         hold.m12, hold.m21, hold.m22, hold.m11};
        ops_next.mcol = {hold.m20, hold.m10, hold.m00};
      end
      ROW1: begin
        ops_next.fac  = {hold.m12, hold.m00, hold.m02, hold.m10,
                         hold.m02, hold.m20, hold.m22, hold.m00,
                         hold.m22, hold.m10, hold.m12, hold.m20};
        ops_next.mcol = {hold.m21, hold.m11, hold.m01};
      end
      ROW2: begin
        ops_next.fac  = {hold.m01, hold.m10, hold.m11, hold.m00,
                         hold.m21, hold.m00, hold.m01, hold.m20,
                         hold.m11, hold.m20, hold.m21, hold.m10};
        ops_next.mcol = {hold.m22, hold.m12, hold.m02};
      end
      default: begin
        ops_next.valid = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      active    <= 1'b0;
      cnt       <= ROW0;
      ops.valid <= 1'b0;
    end else begin
      ops <= ops_next;
      if (accept) begin
        hold   <= xform;
        active <= 1'b1;
        cnt    <= ROW0;
      end else if (active) begin
        if (cnt == ROW2) begin
          active <= 1'b0;
        end else begin
          cnt <= cnt + 2'd1;
        end
      end
    end
  end

endmodule

// ===== design/ati_front.sv =====
// ----------------------------------------------------------------------------
// ati_front
// Five-stage row front end: minors, cofactors, split products, determinant
// and translation sums, then magnitudes and the singular decision.
// ----------------------------------------------------------------------------
module ati_front import ati_pkg::*; #(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  row_ops_t             ops,
  input  logic [THR_WIDTH-1:0] thr,
  output front_t               res
);

  localparam int W  = DATA_WIDTH;
  localparam int PW = 2 * W;
  localparam int MW = 2 * W + 1;

  logic       v1, v2, v3, v4;
  logic [1:0] r1, r2, r3, r4;

  logic signed [PW-1:0]        p1 [6];
  logic [2:0][W-1:0]           mc1, t1, mc2, t2;
  logic signed [COF_WIDTH-1:0] c2 [3];
  logic signed [COF_WIDTH-1:0] c3 [3];
  logic signed [COF_WIDTH-1:0] c4 [3];
  logic signed [MW-1:0]        lm3 [3];
  logic signed [MW-1:0]        hm3 [3];
  logic signed [MW-1:0]        lt3 [3];
  logic signed [MW-1:0]        ht3 [3];
  logic signed [DET_WIDTH-1:0] d4, s4;
  logic signed [DET_WIDTH-1:0] d_sum, s_sum;
  front_t                      res_next;

  // The cofactor is split as hi*2^W + lo so each product stays about W by W.
  always_comb begin
    d_sum = '0;
    s_sum = '0;
    for (int j = 0; j < 3; j++) begin
      d_sum = d_sum + (DET_WIDTH'(hm3[j]) <<< W) + DET_WIDTH'(lm3[j]);
      s_sum = s_sum + (DET_WIDTH'(ht3[j]) <<< W) + DET_WIDTH'(lt3[j]);
    end
  end

  always_comb begin
    res_next          = '0;
    res_next.valid    = v4;
    res_next.row      = r4;
    res_next.det_neg  = d4[DET_WIDTH-1];
    res_next.adet     = d4[DET_WIDTH-1] ? DET_WIDTH'(-d4) : DET_WIDTH'(d4);
    res_next.singular = res_next.adet <= (DET_WIDTH'(thr) << (2 * FRAC_BITS));
    res_next.num_neg  = !s4[DET_WIDTH-1];
    res_next.anum     = s4[DET_WIDTH-1] ? DET_WIDTH'(-s4) : DET_WIDTH'(s4);
    for (int j = 0; j < 3; j++) begin
      res_next.cof_neg[j] = c4[j][COF_WIDTH-1];
      res_next.acof[j]    = c4[j][COF_WIDTH-1] ? COF_WIDTH'(-c4[j]) : COF_WIDTH'(c4[j]);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1        <= 1'b0;
      v2        <= 1'b0;
      v3        <= 1'b0;
      v4        <= 1'b0;
      res.valid <= 1'b0;
    end else begin
      v1  <= ops.valid;
      v2  <= v1;
      v3  <= v2;
      v4  <= v3;
      r1  <= ops.row;
      r2  <= r1;
      r3  <= r2;
      r4  <= r3;
      mc1 <= ops.mcol;
      t1  <= ops.tv;
      mc2 <= mc1;
      t2  <= t1;
      for (int k = 0; k < 6; k++) begin
        p1[k] <= $signed(ops.fac[2*k]) * $signed(ops.fac[2*k+1]);
      end
      for (int j = 0; j < 3; j++) begin
        c2[j]  <= COF_WIDTH'(p1[2*j]) - COF_WIDTH'(p1[2*j+1]);
        c3[j]  <= c2[j];
        c4[j]  <= c3[j];
        lm3[j] <= $signed({1'b0, c2[j][W-1:0]}) * $signed(mc2[j]);
        hm3[j] <= $signed(c2[j][COF_WIDTH-1:W]) * $signed(mc2[j]);
        lt3[j] <= $signed({1'b0, c2[j][W-1:0]}) * $signed(t2[j]);
        ht3[j] <= $signed(c2[j][COF_WIDTH-1:W]) * $signed(t2[j]);
      end
      d4  <= d_sum;
      s4  <= s_sum;
      res <= res_next;
    end
  end

endmodule

// ===== design/ati_div.sv =====
// ----------------------------------------------------------------------------
// ati_div
// Pipelined restoring divider, one quotient bit per stage, with rounding to
// nearest (ties away from zero) and signed saturation of the result.
// ----------------------------------------------------------------------------
module ati_div #(
  parameter int NUMW = 97,
  parameter int DENW = 99,
  parameter int QB   = 33,
  parameter int OUTW = 32
) (
  input  logic            clk,
  input  logic [NUMW-1:0] num,
  input  logic [DENW-1:0] den,
  input  logic            neg,
  output logic [OUTW-1:0] quo
);

  localparam int EW = (NUMW > DENW + QB) ? NUMW : DENW + QB;
  localparam logic [QB:0] MAXP = {{(QB+1-OUTW){1'b0}}, 1'b0, {(OUTW-1){1'b1}}};
  localparam logic [QB:0] MINM = {{(QB+1-OUTW){1'b0}}, 1'b1, {(OUTW-1){1'b0}}};
  localparam logic [OUTW-1:0] SAT_HI = {1'b0, {(OUTW-1){1'b1}}};
  localparam logic [OUTW-1:0] SAT_LO = {1'b1, {(OUTW-1){1'b0}}};

  logic [EW-1:0]   rem [QB+1];
  logic [QB-1:0]   qv  [QB+1];
  logic [DENW-1:0] dv  [QB+1];
  logic            ng  [QB+1];
  logic            ov  [QB+1];
  logic [EW-1:0]   sh   [1:QB];
  logic            take [1:QB];
  logic            rup;
  logic [QB:0]     mag, negm;
  logic [OUTW-1:0] quo_next;

  always_comb begin
    for (int k = 1; k <= QB; k++) begin
      sh[k]   = EW'(dv[k-1]) << (QB - k);
      take[k] = rem[k-1] >= sh[k];
    end
  end

  always_comb begin
    rup  = ({1'b0, rem[QB]} << 1) >= (EW+1)'(dv[QB]);
    mag  = (QB+1)'(qv[QB]) + (QB+1)'(rup);
    negm = -mag;
    if (ov[QB]) begin
      quo_next = ng[QB] ? SAT_LO : SAT_HI;
    end else if (!ng[QB]) begin
      quo_next = (mag > MAXP) ? SAT_HI : mag[OUTW-1:0];
    end else begin
      quo_next = (mag > MINM) ? SAT_LO : negm[OUTW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    rem[0] <= EW'(num);
    qv[0]  <= '0;
    dv[0]  <= den;
    ng[0]  <= neg;
    ov[0]  <= EW'(num) >= (EW'(den) << QB);
    for (int k = 1; k <= QB; k++) begin
      rem[k] <= take[k] ? rem[k-1] - sh[k] : rem[k-1];
      qv[k]  <= qv[k-1] | (QB'(take[k]) << (QB - k));
      dv[k]  <= dv[k-1];
      ng[k]  <= ng[k-1];
      ov[k]  <= ov[k-1];
    end
    quo <= quo_next;
  end

endmodule

// ===== design/affine_transform_inverse_core.sv =====
// ----------------------------------------------------------------------------
// affine_transform_inverse_core
// Inverse of a 3x3 matrix plus translation in signed fixed point, by the
// adjugate and the determinant, delivered as three row results per item.
// ----------------------------------------------------------------------------
//
//   Channel   Handshake                    Payload
//   --------  ---------------------------  -----------------------------------
//   input     start / busy                 xform  (in_item_t)
//   result    result_valid (strobe)        result (out_item_t)
//   config    APB psel/penable/pwrite      paddr, pwdata, prdata
//
// An item is taken when start is high and busy is low. The row sequencer
// issues rows 0, 1, 2 on consecutive cycles; busy rises once an item is taken
// and falls as its row 2 is issued, when the next item can already be taken.
// On its way out, each row passes one issue stage, five front stages, and a
// divider of one stage per quotient bit plus entry and rounding stages. The
// three rows leave on adjacent cycles.
// The result side has no back-pressure: every result is shown for one cycle.
// Synchronous reset clears the sequencer, all valid bits and the threshold.
//
module affine_transform_inverse_core import ati_pkg::*; #(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  output logic                  busy,
  input  in_item_t              xform,
  output logic                  result_valid,
  output out_item_t             result,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [ADDR_WIDTH-1:0] paddr,
  input  logic [APB_WIDTH-1:0]  pwdata,
  output logic [APB_WIDTH-1:0]  prdata,
  output logic                  pready
);

  `include "affine_transform_inverse_core_assert.svh"

  localparam int W   = DATA_WIDTH;
  localparam int QB  = DATA_WIDTH + 1;           // quotient bits before rounding
  localparam int DL  = QB + 2;                   // stages of each divider
  localparam int NCW = COF_WIDTH + 2 * FRAC_BITS;
  localparam int NTW = DET_WIDTH + FRAC_BITS;
  localparam logic [DET_WIDTH:0] W_MAXP = (DET_WIDTH+1)'({1'b0, {(W-1){1'b1}}});
  localparam logic [DET_WIDTH:0] W_MINM = (DET_WIDTH+1)'({1'b1, {(W-1){1'b0}}});

  // Control that rides alongside the dividers.
  typedef struct packed {
    logic [1:0] row;
    logic       singular;
    logic       last;
  } tag_t;

  logic [THR_WIDTH-1:0] thr;
  row_ops_t             ops;
  front_t               f;

  logic [NCW-1:0]       cnum [3];
  logic                 cneg [3];
  logic [W-1:0]         cq   [3];
  logic [DET_WIDTH-1:0] cden, tden;
  logic [NTW-1:0]       tnum;
  logic                 tneg;
  logic [W-1:0]         tq;

  logic [DET_WIDTH:0]   wsum, wmag, wnegm;
  logic [W-1:0]         w_next;

  logic                 vd [DL];
  tag_t                 pd [DL];
  logic [W-1:0]         wd [DL];

  ati_cfg u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .thr     (thr)
  );

  ati_row_seq u_seq (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .xform (xform),
    .busy  (busy),
    .ops   (ops)
  );

  ati_front #(.FRAC_BITS(FRAC_BITS)) u_front (
    .clk (clk),
    .rst (rst),
    .ops (ops),
    .thr (thr),
    .res (f)
  );

  // A singular matrix divides by a power of two instead of the determinant,
  // so the same dividers also do the rounded rescaling of the adjugate.
  assign cden = f.singular ? (DET_WIDTH'(1) << FRAC_BITS) : f.adet;
  assign tden = f.singular ? (DET_WIDTH'(1) << (2 * FRAC_BITS)) : f.adet;
  assign tnum = f.singular ? NTW'(f.anum) : (NTW'(f.anum) << FRAC_BITS);
  assign tneg = f.num_neg ^ (!f.singular && f.det_neg);

  for (genvar j = 0; j < 3; j++) begin : g_col
    assign cnum[j] = f.singular ? NCW'(f.acof[j]) : (NCW'(f.acof[j]) << (2 * FRAC_BITS));
    assign cneg[j] = f.cof_neg[j] ^ (!f.singular && f.det_neg);

    ati_div #(.NUMW(NCW), .DENW(DET_WIDTH), .QB(QB), .OUTW(W)) u_div (
      .clk (clk),
      .num (cnum[j]),
      .den (cden),
      .neg (cneg[j]),
      .quo (cq[j])
    );
  end

  ati_div #(.NUMW(NTW), .DENW(DET_WIDTH), .QB(QB), .OUTW(W)) u_tdiv (
    .clk (clk),
    .num (tnum),
    .den (tden),
    .neg (tneg),
    .quo (tq)
  );

  // w is one when invertible, otherwise the determinant rounded back to the
  // output scale and saturated.
  always_comb begin
    wsum  = (DET_WIDTH+1)'(f.adet) + ((DET_WIDTH+1)'(1) << (2 * FRAC_BITS - 1));
    wmag  = f.singular ? (wsum >> (2 * FRAC_BITS)) : ((DET_WIDTH+1)'(1) << FRAC_BITS);
    wnegm = -wmag;
    if (f.singular && f.det_neg) begin
      w_next = (wmag > W_MINM) ? W_MINM[W-1:0] : wnegm[W-1:0];
    end else begin
      w_next = (wmag > W_MAXP) ? W_MAXP[W-1:0] : wmag[W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < DL; k++) begin
        vd[k] <= 1'b0;
      end
    end else begin
      vd[0]          <= f.valid;
      pd[0].row      <= f.row;
      pd[0].singular <= f.singular;
      pd[0].last     <= (f.row == ROW2);
      wd[0]          <= w_next;
      for (int k = 1; k < DL; k++) begin
        vd[k] <= vd[k-1];
        pd[k] <= pd[k-1];
        wd[k] <= wd[k-1];
      end
    end
  end

  assign result_valid       = vd[DL-1];
  assign result.row_index   = pd[DL-1].row;
  assign result.col0        = cq[0];
  assign result.col1        = cq[1];
  assign result.col2        = cq[2];
  assign result.trans       = tq;
  assign result.singular    = pd[DL-1].singular;
  assign result.w_out       = wd[DL-1];
  assign result.last        = pd[DL-1].last;

  `ATI_ASSERT_NEXT(a_accept_busy, clk, rst, start && !busy, busy)
  `ATI_ASSERT_NEXT(a_rows_adjacent, clk, rst, result_valid && !result.last, result_valid && (result.row_index == $past(result.row_index) + 2'd1))
  `ATI_ASSERT_NEXT(a_item_steady, clk, rst, result_valid && !result.last, (result.singular == $past(result.singular)) && (result.w_out == $past(result.w_out)))

endmodule
